@@ rtl/batch_frame_decoder_macros.svh @@
// assertion macros of the batch frame decoder rtl
`ifndef BATCH_FRAME_DECODER_MACROS_SVH
`define BATCH_FRAME_DECODER_MACROS_SVH
`ifndef SYNTH
// clocked check, off while reset is held
`define BFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also runs through reset
`define BFD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BFD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/bfd_pkg.sv @@
// types, constants and helper functions of the batch frame decoder
`default_nettype none
package bfd_pkg;

  // frame limits
  localparam int unsigned MAX_RECORDS     = 8;
  localparam int unsigned MAX_FRAME_BYTES = 252;

  // fnv-1a 32
  localparam logic [31:0] FNV_INIT  = 32'h811C_9DC5;
  localparam int unsigned HASH_LAG  = 4;

  // magic and frame type bytes
  localparam logic [7:0] MAGIC_0    = 8'h57;
  localparam logic [7:0] MAGIC_1    = 8'h42;
  localparam logic [7:0] MAGIC_2    = 8'h4C;
  localparam logic [7:0] MAGIC_3    = 8'h52;
  localparam logic [7:0] BATCH_TYPE = 8'h01;

  // header layout
  localparam int unsigned OFF_VERSION   = 4;
  localparam int unsigned OFF_TYPE      = 5;
  localparam int unsigned OFF_NODE      = 6;
  localparam int unsigned OFF_BOOT      = 10;
  localparam int unsigned OFF_SEQ       = 14;
  localparam int unsigned OFF_BASE      = 18;
  localparam int unsigned OFF_COUNT     = 22;
  localparam int unsigned OFF_FLAGS     = 23;
  localparam int unsigned HDR_BYTES     = 24;
  localparam int unsigned FIXED_BYTES   = 28;
  localparam int unsigned MIN_FRAME     = 44;
  localparam int unsigned MAGIC_MIN_LEN = 10;
  localparam int unsigned CHANNEL_LIMIT = 48;

  localparam logic [8:0] OFFSET_SAT = 9'd511;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AIR_VERSION,
    CFG_MAX_TYPE,
    CFG_MAX_QUALITY
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_OK,
    ST_MAGIC,
    ST_SHORT,
    ST_LONG,
    ST_CHECKSUM,
    ST_COUNT,
    ST_LENGTH,
    ST_CHANNEL,
    ST_TYPE,
    ST_QUALITY
  } status_t;

  typedef struct packed {
    logic [7:0] air_version;
    logic [7:0] max_record_type;
    logic [7:0] max_time_quality;
  } cfg_t;

  typedef struct packed {
    logic step;     // a byte is consumed this cycle
    logic hash_on;  // the byte leaving the lag line is hashed
    logic clear;    // frame end, restart the hash
  } hash_ctl_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    status_t     status;
    logic [31:0] uid;
    logic [7:0]  channel;
    logic [7:0]  record_type;
    logic [31:0] timestamp;
    logic [7:0]  item_flags;
    logic [7:0]  time_quality;
    logic [31:0] value_bits;
    logic [31:0] boot_id;
    logic [31:0] sequence_res;
    logic [7:0]  record_count;
  } result_t;

  // multiply by the fnv prime 0x01000193 as a shift-add tree
  function automatic logic [31:0] fnv_mul(input logic [31:0] x);
    fnv_mul = (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
  endfunction

endpackage
`default_nettype wire

@@ rtl/bfd_ifs.sv @@
// valid/ready channel interfaces for frame bytes and decoded results
`default_nettype none
interface bfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface bfd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [3:0]  status;
  logic [31:0] uid;
  logic [7:0]  channel;
  logic [7:0]  record_type;
  logic [31:0] timestamp;
  logic [7:0]  item_flags;
  logic [7:0]  time_quality;
  logic [31:0] value_bits;
  logic [31:0] boot_id;
  logic [31:0] sequence_res;
  logic [7:0]  record_count;

  modport source (
    output valid, output result_kind, output status, output uid, output channel,
    output record_type, output timestamp, output item_flags, output time_quality,
    output value_bits, output boot_id, output sequence_res, output record_count,
    input ready
  );
  modport sink (
    input valid, input result_kind, input status, input uid, input channel,
    input record_type, input timestamp, input item_flags, input time_quality,
    input value_bits, input boot_id, input sequence_res, input record_count,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/bfd_hash.sv @@
// four-byte lag line and fnv-1a 32 running hash with trailer compare
`default_nettype none
module bfd_hash import bfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  hash_ctl_t  ctl,
  input  logic [7:0] byte_i,
  output logic       sum_ok
);

  logic [7:0]  lag_r [0:3];
  logic [31:0] hash_r;
  logic [31:0] hash_nxt;

  always_comb begin
    hash_nxt = hash_r;
    if (ctl.hash_on) begin
      hash_nxt = fnv_mul(hash_r ^ {24'd0, lag_r[0]});
    end
  end

  // trailer as it stands after this byte enters the lag line
  assign sum_ok = ({byte_i, lag_r[3], lag_r[2], lag_r[1]} == hash_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_INIT;
      for (int i = 0; i < 4; i++) lag_r[i] <= 8'd0;
    end else if (ctl.step) begin
      if (ctl.clear) begin
        hash_r <= FNV_INIT;
        for (int i = 0; i < 4; i++) lag_r[i] <= 8'd0;
      end else begin
        hash_r   <= hash_nxt;
        lag_r[0] <= lag_r[1];
        lag_r[1] <= lag_r[2];
        lag_r[2] <= lag_r[3];
        lag_r[3] <= byte_i;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/bfd_parse.sv @@
// header capture, record assembly, record checks and frame status
`default_nettype none
module bfd_parse import bfd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg,
  input  logic       sum_ok,
  output hash_ctl_t  hctl,
  output result_t    res
);

  logic [8:0]  pos_r, pos_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [31:0] node_r, node_nxt;
  logic [31:0] boot_r, boot_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] base_r, base_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  bflags_r, bflags_nxt;
  status_t     err_r, err_nxt;
  logic [7:0]  rec_r [0:14];

  logic        placed;
  logic [9:0]  len;
  logic [3:0]  k;
  logic        in_rec;
  logic        rec_done;
  status_t     rec_chk;
  status_t     frame_st;
  logic [12:0] need_len;

  assign placed   = (pos_r != OFFSET_SAT);
  assign len      = {1'b0, pos_r} + 10'd1;
  assign k        = pos_r[3:0] + 4'd8;
  assign in_rec   = placed && (pos_r >= 9'(HDR_BYTES));
  assign rec_done = in_rec && (k == 4'hF);
  assign need_len = 13'(FIXED_BYTES) + {1'b0, count_nxt, 4'b0000};

  assign hctl.step    = step;
  assign hctl.hash_on = (pos_r >= 9'(HASH_LAG));
  assign hctl.clear   = last_i;

  // header fields and magic, version and frame type checks
  always_comb begin
    pos_nxt    = pos_r;
    hdr_ok_nxt = hdr_ok_r;
    node_nxt   = node_r;
    boot_nxt   = boot_r;
    seq_nxt    = seq_r;
    base_nxt   = base_r;
    count_nxt  = count_r;
    bflags_nxt = bflags_r;
    if (placed) begin
      pos_nxt = pos_r + 9'd1;
      case (pos_r)
        9'd0: if (byte_i != MAGIC_0) hdr_ok_nxt = 1'b0;
        9'd1: if (byte_i != MAGIC_1) hdr_ok_nxt = 1'b0;
        9'd2: if (byte_i != MAGIC_2) hdr_ok_nxt = 1'b0;
        9'd3: if (byte_i != MAGIC_3) hdr_ok_nxt = 1'b0;
        9'(OFF_VERSION): if (byte_i != cfg.air_version) hdr_ok_nxt = 1'b0;
        9'(OFF_TYPE): if (byte_i != BATCH_TYPE) hdr_ok_nxt = 1'b0;
        default: ;
      endcase
      if (pos_r >= 9'(OFF_NODE) && pos_r < 9'(OFF_BOOT)) begin
        node_nxt = {byte_i, node_r[31:8]};
      end else if (pos_r >= 9'(OFF_BOOT) && pos_r < 9'(OFF_SEQ)) begin
        boot_nxt = {byte_i, boot_r[31:8]};
      end else if (pos_r >= 9'(OFF_SEQ) && pos_r < 9'(OFF_BASE)) begin
        seq_nxt = {byte_i, seq_r[31:8]};
      end else if (pos_r >= 9'(OFF_BASE) && pos_r < 9'(OFF_COUNT)) begin
        base_nxt = {byte_i, base_r[31:8]};
      end else if (pos_r == 9'(OFF_COUNT)) begin
        count_nxt = byte_i;
      end else if (pos_r == 9'(OFF_FLAGS)) begin
        bflags_nxt = byte_i;
      end
    end
  end

  // record checks, first failure wins
  always_comb begin
    if (rec_r[4] >= 8'(CHANNEL_LIMIT)) begin
      rec_chk = ST_CHANNEL;
    end else if (rec_r[5] > cfg.max_record_type) begin
      rec_chk = ST_TYPE;
    end else if (rec_r[11] > cfg.max_time_quality) begin
      rec_chk = ST_QUALITY;
    end else begin
      rec_chk = ST_OK;
    end
    err_nxt = err_r;
    if (rec_done && err_r == ST_OK) err_nxt = rec_chk;
  end

  // frame status in check order
  always_comb begin
    if (len < 10'(MAGIC_MIN_LEN) || !hdr_ok_nxt) begin
      frame_st = ST_MAGIC;
    end else if (len < 10'(MIN_FRAME)) begin
      frame_st = ST_SHORT;
    end else if (len > 10'(MAX_FRAME_BYTES)) begin
      frame_st = ST_LONG;
    end else if (!sum_ok) begin
      frame_st = ST_CHECKSUM;
    end else if (count_nxt == 8'd0 || count_nxt > 8'(MAX_RECORDS)) begin
      frame_st = ST_COUNT;
    end else if (need_len != {3'b000, len}) begin
      frame_st = ST_LENGTH;
    end else begin
      frame_st = err_nxt;
    end
  end

  always_comb begin
    res              = '0;
    res.valid        = step && (last_i || rec_done);
    res.kind         = last_i;
    res.boot_id      = boot_nxt;
    res.sequence_res = seq_nxt;
    res.record_count = count_nxt;
    if (last_i) begin
      res.status     = frame_st;
      res.uid        = node_nxt;
      res.timestamp  = base_nxt;
      res.item_flags = bflags_nxt;
    end else begin
      res.status       = ST_OK;
      res.uid          = {rec_r[3], rec_r[2], rec_r[1], rec_r[0]};
      res.channel      = rec_r[4];
      res.record_type  = rec_r[5];
      res.timestamp    = base_r + {rec_r[9], rec_r[8], rec_r[7], rec_r[6]};
      res.item_flags   = rec_r[10];
      res.time_quality = rec_r[11];
      res.value_bits   = {byte_i, rec_r[14], rec_r[13], rec_r[12]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 9'd0;
      hdr_ok_r <= 1'b1;
      node_r   <= 32'd0;
      boot_r   <= 32'd0;
      seq_r    <= 32'd0;
      base_r   <= 32'd0;
      count_r  <= 8'd0;
      bflags_r <= 8'd0;
      err_r    <= ST_OK;
    end else if (step) begin
      if (last_i) begin
        pos_r    <= 9'd0;
        hdr_ok_r <= 1'b1;
        node_r   <= 32'd0;
        boot_r   <= 32'd0;
        seq_r    <= 32'd0;
        base_r   <= 32'd0;
        count_r  <= 8'd0;
        bflags_r <= 8'd0;
        err_r    <= ST_OK;
      end else begin
        pos_r    <= pos_nxt;
        hdr_ok_r <= hdr_ok_nxt;
        node_r   <= node_nxt;
        boot_r   <= boot_nxt;
        seq_r    <= seq_nxt;
        base_r   <= base_nxt;
        count_r  <= count_nxt;
        bflags_r <= bflags_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  // record byte 15 is used live, only 0..14 are stored
  always_ff @(posedge clk) begin
    if (step && in_rec && k != 4'hF) begin
      rec_r[k] <= byte_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/batch_frame_decoder.sv @@
// top level of the streaming sensor batch frame decoder
`default_nettype none
`include "batch_frame_decoder_macros.svh"
// Takes a radio frame one byte per transaction on in_ch, with frame_end on the
// final byte, and sustains one byte per clock while out_ch is ready. Each byte
// lands in an input register and is decoded once the result register is
// free or being drained: header capture, 16-byte record assembly, record
// checks and one fnv-1a 32 step (a shift-add multiply by the prime, then the
// trailer compare on the final byte) all sit between the input register and
// the result register, which drives out_ch. Every 16th record byte yields a
// record result (timestamp = base + delta mod 2^32) and the final byte yields
// one status result instead; records go out before the frame is checked and
// are to be dropped by the consumer on a nonzero status. A new byte is taken
// while a result waits, until the input register is also full. The three
// 8-bit registers are to be written through cfg_we/cfg_index/cfg_wdata
// between frames, which the block does not enforce; an index past the last
// register is ignored. No clearing pass after reset.
module batch_frame_decoder import bfd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  bfd_in_if.sink               in_ch,
  bfd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  // decode advances when the result register is free or being drained
  logic       adv;
  logic       in_take;

  logic       out_valid_r;
  result_t    res;
  result_t    res_r;

  hash_ctl_t  hctl;
  logic       sum_ok;
  cfg_t       cfg_r;

  assign adv          = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || adv;
  assign in_take      = in_ch.valid && in_ch.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.air_version      <= 8'd1;
      cfg_r.max_record_type  <= 8'd3;
      cfg_r.max_time_quality <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AIR_VERSION: cfg_r.air_version      <= cfg_wdata;
        CFG_MAX_TYPE:    cfg_r.max_record_type  <= cfg_wdata;
        CFG_MAX_QUALITY: cfg_r.max_time_quality <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.frame_byte;
      in_end_r  <= in_ch.frame_end;
    end
  end

  bfd_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (hctl),
    .byte_i (in_byte_r),
    .sum_ok (sum_ok)
  );

  bfd_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .byte_i (in_byte_r),
    .last_i (in_end_r),
    .cfg    (cfg_r),
    .sum_ok (sum_ok),
    .hctl   (hctl),
    .res    (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res.valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = res_r.kind;
  assign out_ch.status       = res_r.status;
  assign out_ch.uid          = res_r.uid;
  assign out_ch.channel      = res_r.channel;
  assign out_ch.record_type  = res_r.record_type;
  assign out_ch.timestamp    = res_r.timestamp;
  assign out_ch.item_flags   = res_r.item_flags;
  assign out_ch.time_quality = res_r.time_quality;
  assign out_ch.value_bits   = res_r.value_bits;
  assign out_ch.boot_id      = res_r.boot_id;
  assign out_ch.sequence_res = res_r.sequence_res;
  assign out_ch.record_count = res_r.record_count;

  // a result only appears after a decode step
  `BFD_ASSERT(a_rise_after_step, clk, rst_n, $rose(out_valid_r) |-> $past(adv), "result without decode step")
  // a byte waiting for decode is not lost
  `BFD_ASSERT(a_in_held, clk, rst_n, in_valid_r && !adv |=> in_valid_r, "pending byte dropped")
  // record transactions carry a zero status
  `BFD_ASSERT(a_rec_status, clk, rst_n, out_valid_r && !res_r.kind |-> res_r.status == ST_OK, "record with status")
  // frame status stays within the defined codes
  `BFD_ASSERT(a_status_code, clk, rst_n, out_valid_r && res_r.kind |-> res_r.status <= ST_QUALITY, "bad status code")
  // reset empties both stages
  `BFD_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_valid_r && !in_valid_r, "stage valid after reset")

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// self-checking testbench of the batch frame decoder, with its own decode model
`default_nettype none
module tb;
  import bfd_pkg::*;

  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  // byte positions inside one 16-byte record
  localparam int unsigned REC_BYTES   = 16;
  localparam int unsigned REC_CHANNEL = 4;
  localparam int unsigned REC_TYPE    = 5;
  localparam int unsigned REC_DELTA   = 6;
  localparam int unsigned REC_FLAGS   = 10;
  localparam int unsigned REC_QUALITY = 11;
  localparam int unsigned REC_VALUE   = 12;
  // the one register index that selects nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam logic [7:0] MAGIC_BYTES [4] = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_wdata;

  bfd_in_if  in_ch();
  bfd_out_if out_ch();

  batch_frame_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // decoder model: register copies, then per-frame state
  logic [7:0]  air_ver       = 8'd1;
  logic [7:0]  type_limit    = 8'd3;
  logic [7:0]  quality_limit = 8'd2;

  int          byte_pos;
  logic [7:0]  lag_line [4];
  logic [31:0] hash_acc;
  bit          hdr_good;
  logic [31:0] node_uid, boot_val, seq_val, base_val;
  logic [7:0]  hdr_count, hdr_flags;
  logic [7:0]  rec_buf [16];
  status_t     first_bad;

  result_t     decoded_queue [$];   // results the decoder still owes us
  result_t     want;
  int          mismatches   = 0;
  int          results_seen = 0;
  int          bytes_sent   = 0;
  bit          no_idle      = 1'b0;

  logic [7:0]  frame_buf [$];       // frame under construction

  // per-frame state back to its start values
  task automatic restart_frame();
    byte_pos  = 0;
    lag_line  = '{default: 8'd0};
    hash_acc  = FNV_INIT;
    hdr_good  = 1'b1;
    node_uid  = '0;
    boot_val  = '0;
    seq_val   = '0;
    base_val  = '0;
    hdr_count = '0;
    hdr_flags = '0;
    first_bad = ST_OK;
  endtask

  // advance the model by one accepted byte and queue what it must produce
  task automatic decode_byte(input logic [7:0] b, input logic last);
    int      pos;
    int      k;
    int      len;
    bit      placed;
    bit      rec_done;
    status_t err;
    status_t st;
    result_t r;
    pos      = byte_pos;
    placed   = pos < int'(OFFSET_SAT);
    rec_done = 1'b0;

    // the byte leaving the lag line joins the hash, the trailer never does
    if (pos >= 4) hash_acc = (hash_acc ^ {24'd0, lag_line[0]}) * FNV_PRIME;
    lag_line[0] = lag_line[1];
    lag_line[1] = lag_line[2];
    lag_line[2] = lag_line[3];
    lag_line[3] = b;

    if (placed) begin
      if (pos < OFF_VERSION && b != MAGIC_BYTES[pos]) hdr_good = 1'b0;
      if (pos == OFF_VERSION && b != air_ver) hdr_good = 1'b0;
      if (pos == OFF_TYPE && b != BATCH_TYPE) hdr_good = 1'b0;
      if (pos >= OFF_NODE && pos < OFF_BOOT) node_uid = {b, node_uid[31:8]};
      else if (pos >= OFF_BOOT && pos < OFF_SEQ) boot_val = {b, boot_val[31:8]};
      else if (pos >= OFF_SEQ && pos < OFF_BASE) seq_val = {b, seq_val[31:8]};
      else if (pos >= OFF_BASE && pos < OFF_COUNT) base_val = {b, base_val[31:8]};
      else if (pos == OFF_COUNT) hdr_count = b;
      else if (pos == OFF_FLAGS) hdr_flags = b;
      else if (pos >= HDR_BYTES) begin
        k = (pos - HDR_BYTES) % REC_BYTES;
        rec_buf[k] = b;
        if (k == REC_BYTES - 1) begin
          rec_done = 1'b1;
          err = ST_OK;
          if (rec_buf[REC_CHANNEL] >= CHANNEL_LIMIT) err = ST_CHANNEL;
          else if (rec_buf[REC_TYPE] > type_limit) err = ST_TYPE;
          else if (rec_buf[REC_QUALITY] > quality_limit) err = ST_QUALITY;
          if (first_bad == ST_OK) first_bad = err;
        end
      end
      byte_pos = pos + 1;
    end

    r = '0;
    r.boot_id      = boot_val;
    r.sequence_res = seq_val;
    r.record_count = hdr_count;
    if (last) begin
      // a saturated counter stands for a length that is always too long
      len = placed ? pos + 1 : int'(OFFSET_SAT) + 1;
      if (len < MAGIC_MIN_LEN || !hdr_good) st = ST_MAGIC;
      else if (len < MIN_FRAME) st = ST_SHORT;
      else if (len > MAX_FRAME_BYTES) st = ST_LONG;
      else if ({lag_line[3], lag_line[2], lag_line[1], lag_line[0]} != hash_acc)
        st = ST_CHECKSUM;
      else if (hdr_count == 0 || hdr_count > MAX_RECORDS) st = ST_COUNT;
      else if (FIXED_BYTES + hdr_count * REC_BYTES != len) st = ST_LENGTH;
      else st = first_bad;
      r.kind       = 1'b1;
      r.status     = st;
      r.uid        = node_uid;
      r.timestamp  = base_val;
      r.item_flags = hdr_flags;
      decoded_queue.push_back(r);
      restart_frame();
    end else if (rec_done) begin
      r.kind         = 1'b0;
      r.status       = ST_OK;
      r.uid          = {rec_buf[3], rec_buf[2], rec_buf[1], rec_buf[0]};
      r.channel      = rec_buf[REC_CHANNEL];
      r.record_type  = rec_buf[REC_TYPE];
      r.timestamp    = base_val + {rec_buf[REC_DELTA+3], rec_buf[REC_DELTA+2],
                                   rec_buf[REC_DELTA+1], rec_buf[REC_DELTA]};
      r.item_flags   = rec_buf[REC_FLAGS];
      r.time_quality = rec_buf[REC_QUALITY];
      r.value_bits   = {rec_buf[REC_VALUE+3], rec_buf[REC_VALUE+2],
                        rec_buf[REC_VALUE+1], rec_buf[REC_VALUE]};
      decoded_queue.push_back(r);
    end
  endtask

  // every accepted byte goes through the model
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) decode_byte(in_ch.frame_byte, in_ch.frame_end);
  end

  // result side back-pressure: ready drops with an 18 percent chance unless no_idle
  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99, 0) >= 18);
  end

  task automatic match_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // each result transaction against the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (decoded_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                 $time, out_ch.result_kind, out_ch.status);
        mismatches++;
      end else begin
        want = decoded_queue.pop_front();
        match_field("result_kind",  32'(want.kind),         32'(out_ch.result_kind));
        match_field("status",       32'(want.status),       32'(out_ch.status));
        match_field("uid",          want.uid,               out_ch.uid);
        match_field("channel",      32'(want.channel),      32'(out_ch.channel));
        match_field("record_type",  32'(want.record_type),  32'(out_ch.record_type));
        match_field("timestamp",    want.timestamp,         out_ch.timestamp);
        match_field("item_flags",   32'(want.item_flags),   32'(out_ch.item_flags));
        match_field("time_quality", 32'(want.time_quality), 32'(out_ch.time_quality));
        match_field("value_bits",   want.value_bits,        out_ch.value_bits);
        match_field("boot_id",      want.boot_id,           out_ch.boot_id);
        match_field("sequence_res", want.sequence_res,      out_ch.sequence_res);
        match_field("record_count", 32'(want.record_count), 32'(out_ch.record_count));
      end
    end
  end

  // one byte transaction; valid stays high unless a gap is drawn
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!no_idle && $urandom_range(99, 0) < 18) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.frame_byte <= b;
    in_ch.frame_end  <= last;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // register write between frames, once nothing is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    in_ch.valid <= 1'b0;
    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_AIR_VERSION: air_ver       = val;
      CFG_MAX_TYPE:    type_limit    = val;
      CFG_MAX_QUALITY: quality_limit = val;
      default: ;
    endcase
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) frame_buf.push_back(w[8*i +: 8]);
  endtask

  // header plus records; sloppy records draw channel, type and quality from
  // the full byte range so the record checks fire now and then
  task automatic build_frame(input logic [7:0] count_byte, input int n_rec, input bit sloppy);
    frame_buf.delete();
    for (int i = 0; i < 4; i++) frame_buf.push_back(MAGIC_BYTES[i]);
    frame_buf.push_back(air_ver);
    frame_buf.push_back(BATCH_TYPE);
    repeat (4) put_word($urandom);   // node, boot, sequence, base time
    frame_buf.push_back(count_byte);
    frame_buf.push_back(8'($urandom));
    repeat (n_rec) begin
      put_word($urandom);
      frame_buf.push_back(sloppy ? 8'($urandom) : 8'($urandom_range(CHANNEL_LIMIT - 1, 0)));
      frame_buf.push_back(sloppy ? 8'($urandom) : 8'($urandom_range(type_limit, 0)));
      put_word($urandom);
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(sloppy ? 8'($urandom) : 8'($urandom_range(quality_limit, 0)));
      put_word($urandom);
    end
  endtask

  function automatic logic [31:0] frame_hash();
    logic [31:0] h;
    h = FNV_INIT;
    foreach (frame_buf[i]) h = (h ^ {24'd0, frame_buf[i]}) * FNV_PRIME;
    return h;
  endfunction

  // append the hash trailer, optionally with one bit flipped
  task automatic close_frame(input bit corrupt);
    logic [31:0] h;
    h = frame_hash();
    if (corrupt) h[$urandom_range(31, 0)] ^= 1'b1;
    put_word(h);
  endtask

  task automatic pad_to(input int len);
    while (frame_buf.size() < len) frame_buf.push_back(8'($urandom));
  endtask

  task automatic trim_to(input int len);
    while (frame_buf.size() > len) void'(frame_buf.pop_back());
  endtask

  function automatic int rec_at(input int r, input int j);
    return HDR_BYTES + REC_BYTES * r + j;
  endfunction

  task automatic send_good_frame(input int n_rec, input bit sloppy);
    build_frame(8'(n_rec), n_rec, sloppy);
    close_frame(1'b0);
    send_frame();
  endtask

  // clean frames at the reset settings, the smallest and the largest
  task automatic test_well_formed();
    send_good_frame(1, 1'b0);
    send_good_frame(MAX_RECORDS, 1'b0);
    // base time plus delta wraps past 2^32, zero uid, all-ones value
    build_frame(8'd1, 1, 1'b0);
    for (int i = 0; i < 4; i++) begin
      frame_buf[OFF_BASE + i]              = 8'hFF;
      frame_buf[rec_at(0, REC_DELTA + i)]  = (i == 0) ? 8'h01 : 8'h00;
      frame_buf[rec_at(0, REC_VALUE + i)]  = 8'hFF;
      frame_buf[rec_at(0, i)]              = 8'h00;
    end
    close_frame(1'b0);
    send_frame();
  endtask

  // one wrong bit in each magic, version and frame type byte
  task automatic test_header_checks();
    for (int off = 0; off <= OFF_TYPE; off++) begin
      build_frame(8'd1, 1, 1'b0);
      frame_buf[off] ^= 8'h01 << $urandom_range(7, 0);
      close_frame(1'b0);
      send_frame();
    end
  endtask

  // length, checksum and count checks and their order
  task automatic test_length_checks();
    build_frame(8'd1, 1, 1'b0);
    trim_to(1);                               // single byte frame
    send_frame();
    build_frame(8'd1, 1, 1'b0);
    trim_to(MAGIC_MIN_LEN - 1);               // too short to judge the magic
    send_frame();
    build_frame(8'd1, 1, 1'b0);
    trim_to(MAGIC_MIN_LEN);
    send_frame();
    build_frame(8'd1, 1, 1'b0);
    close_frame(1'b0);
    trim_to(MIN_FRAME - 1);
    send_frame();
    build_frame(8'(MAX_RECORDS), MAX_RECORDS, 1'b0);
    pad_to(MAX_FRAME_BYTES - 4);              // exactly at the limit, wrong length
    close_frame(1'b0);
    send_frame();
    build_frame(8'(MAX_RECORDS), MAX_RECORDS, 1'b0);
    pad_to(MAX_FRAME_BYTES - 3);              // one byte over
    close_frame(1'b0);
    send_frame();
    build_frame(8'd1, 1, 1'b0);
    pad_to(int'(OFFSET_SAT) + 5);             // byte counter saturates
    close_frame(1'b0);
    send_frame();
    build_frame(8'd1, 1, 1'b0);
    close_frame(1'b1);                        // bad trailer
    send_frame();
    build_frame(8'd0, 1, 1'b0);               // zero count
    close_frame(1'b0);
    send_frame();
    build_frame(8'(MAX_RECORDS + 1), 1, 1'b0);
    close_frame(1'b0);
    send_frame();
    build_frame(8'd2, 1, 1'b0);               // count disagrees with length
    close_frame(1'b0);
    send_frame();
    // final byte completes a record, the status wins
    build_frame(8'd1, 2, 1'b0);
    pad_to(HDR_BYTES + 3 * REC_BYTES - 4);
    close_frame(1'b0);
    send_frame();
  endtask

  // per-record checks at their boundaries, first error wins
  task automatic test_record_checks();
    build_frame(8'd3, 3, 1'b0);
    frame_buf[rec_at(0, REC_CHANNEL)] = 8'(CHANNEL_LIMIT - 1);
    frame_buf[rec_at(0, REC_TYPE)]    = type_limit;
    frame_buf[rec_at(0, REC_QUALITY)] = quality_limit;
    frame_buf[rec_at(1, REC_CHANNEL)] = 8'(CHANNEL_LIMIT);
    close_frame(1'b0);
    send_frame();
    build_frame(8'd3, 3, 1'b0);
    frame_buf[rec_at(2, REC_TYPE)] = type_limit + 8'd1;
    close_frame(1'b0);
    send_frame();
    build_frame(8'd3, 3, 1'b0);
    frame_buf[rec_at(0, REC_QUALITY)] = quality_limit + 8'd1;
    frame_buf[rec_at(1, REC_CHANNEL)] = 8'hFF;
    close_frame(1'b0);
    send_frame();
    // type checked ahead of quality within one record
    build_frame(8'd2, 2, 1'b0);
    frame_buf[rec_at(1, REC_TYPE)]    = 8'hFF;
    frame_buf[rec_at(1, REC_QUALITY)] = 8'hFF;
    close_frame(1'b0);
    send_frame();
  endtask

  // all registers at both extremes, plus a write to the unused index
  task automatic test_register_extremes();
    write_reg(CFG_AIR_VERSION, 8'h00);
    write_reg(CFG_MAX_TYPE,    8'h00);
    write_reg(CFG_MAX_QUALITY, 8'h00);
    send_good_frame(2, 1'b1);
    send_good_frame(1, 1'b0);
    write_reg(CFG_AIR_VERSION, 8'hFF);
    write_reg(CFG_MAX_TYPE,    8'hFF);
    write_reg(CFG_MAX_QUALITY, 8'hFF);
    send_good_frame(2, 1'b1);
    write_reg(CFG_SPARE_IDX, 8'h00);          // must leave all three alone
    send_good_frame(1, 1'b0);
    build_frame(8'd1, 1, 1'b0);
    frame_buf[OFF_VERSION] = 8'h01;           // reset version no longer matches
    close_frame(1'b0);
    send_frame();
  endtask

  task automatic random_settings();
    write_reg(CFG_AIR_VERSION, 8'($urandom));
    write_reg(CFG_MAX_TYPE,    8'($urandom_range(7, 0)));
    write_reg(CFG_MAX_QUALITY, 8'($urandom_range(7, 0)));
    if ($urandom_range(3, 0) == 0) write_reg(CFG_SPARE_IDX, 8'($urandom));
  endtask

  // mostly well-formed frames with random content, the rest broken or noise
  task automatic test_random_traffic();
    int first_byte;
    int frames;
    int sel;
    int n_rec;
    first_byte = bytes_sent;
    frames     = 0;
    no_idle    = 1'b1;                        // opening stretch runs flat out
    while (bytes_sent - first_byte < 750 || results_seen < 60) begin
      if (bytes_sent - first_byte > 250) no_idle = 1'b0;
      if (frames % 6 == 5) random_settings();
      frames++;
      sel   = $urandom_range(99, 0);
      n_rec = ($urandom_range(9, 0) == 0) ? $urandom_range(MAX_RECORDS, 1)
                                           : $urandom_range(2, 1);
      if (sel < 55) begin
        send_good_frame(n_rec, $urandom_range(3, 0) == 0);
      end else if (sel < 63) begin
        build_frame(8'(n_rec), n_rec, 1'b0);
        close_frame(1'b1);
        send_frame();
      end else if (sel < 71) begin
        build_frame($urandom_range(1, 0) ? 8'(n_rec + 1) : 8'($urandom), n_rec, 1'b0);
        close_frame(1'b0);
        send_frame();
      end else if (sel < 79) begin
        build_frame(8'(n_rec), n_rec, 1'b0);
        frame_buf[$urandom_range(OFF_TYPE, 0)] ^= 8'h01 << $urandom_range(7, 0);
        close_frame(1'b0);
        send_frame();
      end else if (sel < 87) begin
        build_frame(8'(n_rec), n_rec, 1'b0);
        close_frame(1'b0);
        trim_to($urandom_range(frame_buf.size() - 1, 1));
        send_frame();
      end else if (sel < 94) begin
        build_frame(8'(n_rec), n_rec, 1'b0);
        pad_to(frame_buf.size() + $urandom_range(20, 1));
        close_frame(1'b0);
        send_frame();
      end else begin
        frame_buf.delete();
        pad_to($urandom_range(60, 1));
        send_frame();
      end
    end
  endtask

  initial begin
    // everything known from time zero, then reset is held and released
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.frame_byte <= 8'h00;
    in_ch.frame_end  <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_AIR_VERSION;
    cfg_wdata        <= 8'h00;
    restart_frame();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_well_formed();
    test_header_checks();
    test_length_checks();
    test_record_checks();
    test_register_extremes();
    write_reg(CFG_AIR_VERSION, 8'd1);
    write_reg(CFG_MAX_TYPE,    8'd3);
    write_reg(CFG_MAX_QUALITY, 8'd2);
    test_random_traffic();

    // drain: every owed result, then a wait for strays
    in_ch.valid <= 1'b0;
    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && decoded_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
